// ----- rtl/plcm_pkg.sv -----
// Shared types and constants for the piecewise-linear colour map.
// Holds the controller-to-datapath command and status bundles and the fixed widths.
// No dependencies.
package plcm_pkg;

  // Fixed field widths.
  localparam int VAL_W   = 32;   // control point value, signed
  localparam int COL_W   = 8;    // one colour channel
  localparam int IDX_W   = 12;   // table entry index
  localparam int NE_W    = 13;   // entry count register
  localparam int NCL_W   = 17;   // entry count during clamping
  localparam int CH_MAX  = 4;    // colour channels on the ports
  localparam int PI_W    = 4;    // load slot field

  // Largest number of table entries honoured; larger counts are clamped to it.
  localparam int MAX_ENTRIES = 4096;

  // Arithmetic widths.
  localparam int DEN_W   = VAL_W + 1;   // difference of two values, signed
  localparam int DMAG_W  = VAL_W;       // magnitude of such a difference
  localparam int NUM_W   = 45;          // signed dividend
  localparam int MAG_W   = NUM_W - 1;   // dividend magnitude
  localparam int PROD_W  = 42;          // channel times difference, signed

  // Input item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Point store read address selection.
  localparam logic [2:0] RD_ZERO = 3'd0;
  localparam logic [2:0] RD_LAST = 3'd1;
  localparam logic [2:0] RD_J    = 3'd2;
  localparam logic [2:0] RD_LO   = 3'd3;
  localparam logic [2:0] RD_HI   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       start_q;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       latch_first;
    logic       calc_diff;
    logic       calc_mul;
    logic       div_start;
    logic       div_chan;
    logic       latch_v;
    logic       j_inc;
    logic       latch_pair;
    logic       latch_lo;
    logic       calc_span;
    logic       ch_mul;
    logic       ch_sum;
    logic       ch_store;
    logic       ch_inc;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt2;
    logic search_hit;
    logic j_last;
    logic div_done;
    logic span_zero;
    logic ch_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/plcm_div.sv -----
// Shared bit-serial signed divider: one quotient bit per cycle.
// Gives a truncated or a floored quotient. Depends on plcm_pkg.
module plcm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              floor_md,
  input  logic signed [plcm_pkg::NUM_W-1:0] num,
  input  logic signed [plcm_pkg::DEN_W-1:0] den,
  output logic                              done,
  output logic signed [plcm_pkg::NUM_W-1:0] quo
);
  import plcm_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]           a_r;
  logic [DMAG_W-1:0]          b_r;
  logic [DMAG_W-1:0]          rem_r;
  logic                       neg_r;
  logic                       floor_r;
  logic signed [NUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       fin_r, fin_nxt;
  logic                       done_r, done_nxt;

  logic [MAG_W-1:0]           num_mag;
  logic [DMAG_W-1:0]          den_mag;
  logic [DMAG_W:0]            trial;
  logic [DMAG_W:0]            trial_sub;
  logic                       ge;
  logic [NUM_W-1:0]           q_mag;
  logic signed [NUM_W-1:0]    quo_nxt;

  // Operand magnitudes at start.
  always_comb begin
    num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den_mag = den[DEN_W-1] ? DMAG_W'(-den) : DMAG_W'(den);
  end

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial     = {rem_r, a_r[MAG_W-1]};
    trial_sub = trial - {1'b0, b_r};
    ge        = (trial >= {1'b0, b_r});
  end

  // Signed quotient; a floored negative quotient with a remainder is one lower.
  always_comb begin
    q_mag = NUM_W'(a_r);
    if (!neg_r) begin
      quo_nxt = q_mag;
    end else if (floor_r && (rem_r != '0)) begin
      quo_nxt = ~q_mag;
    end else begin
      quo_nxt = -q_mag;
    end
  end

  // Iteration control.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = fin_r;
    if (start) begin
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= num_mag;
      b_r     <= den_mag;
      rem_r   <= '0;
      neg_r   <= num[NUM_W-1] ^ den[DEN_W-1];
      floor_r <= floor_md;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DMAG_W-1:0] : trial[DMAG_W-1:0];
      a_r   <= {a_r[MAG_W-2:0], ge};
    end
    if (fin_r) begin
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  // A new division must not start while one is still running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r && !fin_r))
    else $error("divider started while busy");

endmodule

// ----- rtl/plcm_dpath.sv -----
// Datapath of the colour map: point store, entry value, search, interpolation, result register.
// Driven by plcm_ctrl through cmd_t/sts_t. Depends on plcm_pkg and plcm_div.
module plcm_dpath #(
  parameter int MAX_POINTS = 16,
  parameter int CHANNELS   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [plcm_pkg::NE_W-1:0]            cfg_num_entries,
  input  logic [plcm_pkg::PI_W-1:0]            in_point_index,
  input  logic signed [plcm_pkg::VAL_W-1:0]    in_point_value,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_red,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_green,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_blue,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_alpha,
  input  logic [plcm_pkg::IDX_W-1:0]           in_entry_index,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [plcm_pkg::IDX_W-1:0]           out_entry_out,
  output logic [plcm_pkg::COL_W-1:0]           out_red,
  output logic [plcm_pkg::COL_W-1:0]           out_green,
  output logic [plcm_pkg::COL_W-1:0]           out_blue,
  output logic [plcm_pkg::COL_W-1:0]           out_alpha,
  output logic                                 out_map_valid,
  input  plcm_pkg::cmd_t                       cmd,
  output plcm_pkg::sts_t                       sts
);
  import plcm_pkg::*;

  localparam int PT_AW = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PCW   = COL_W * CHANNELS;
  localparam logic [NCL_W-1:0]      ENT_MAX  = NCL_W'(MAX_ENTRIES);
  localparam logic signed [NUM_W-1:0] CHAN_TOP = NUM_W'(255);

  // Point store: values and colours, one write and one read port each.
  logic [VAL_W-1:0]           val_mem [MAX_POINTS];
  logic [PCW-1:0]             col_mem [MAX_POINTS];
  logic signed [VAL_W-1:0]    vrd_r;
  logic [PCW-1:0]             crd_r;
  logic [PT_AW-1:0]           rd_addr;
  logic [PT_AW-1:0]           last_addr;

  // Configuration and control state.
  logic [NE_W-1:0]            num_entries_r;
  logic [CNT_W-1:0]           count_r;
  logic                       out_valid_r, out_valid_nxt;

  // Query working registers.
  logic [IDX_W-1:0]           idx_r;
  logic [NE_W-1:0]            d_r;
  logic                       lt2_q_r;
  logic signed [VAL_W-1:0]    first_r;
  logic signed [DEN_W-1:0]    diff_r;
  logic signed [NUM_W-1:0]    num_r;
  logic signed [VAL_W-1:0]    v_r;
  logic [PT_AW-1:0]           j_r;
  logic [PT_AW-1:0]           lo_i_r;
  logic [PT_AW-1:0]           hi_i_r;
  logic signed [VAL_W-1:0]    lo_v_r;
  logic [PCW-1:0]             lo_c_r;
  logic [PCW-1:0]             hi_c_r;
  logic signed [DEN_W-1:0]    dhv_r;
  logic signed [DEN_W-1:0]    dvl_r;
  logic signed [DEN_W-1:0]    span_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [PROD_W-1:0]   p1_r;
  logic signed [PROD_W-1:0]   p2_r;
  logic signed [NUM_W-1:0]    cnum_r;
  logic [COL_W-1:0]           res_r [CHANNELS];

  // Result register.
  logic [IDX_W-1:0]           out_entry_r;
  logic                       out_mv_r;
  logic [COL_W-1:0]           out_col_r [CHANNELS];
  logic [COL_W-1:0]           col_o [CH_MAX];

  // Combinational helpers.
  logic [NCL_W-1:0]           n_ext, n_cl, d_full;
  logic [NE_W-1:0]            d_nxt;
  logic [IDX_W-1:0]           idx_nxt;
  logic [PT_AW-1:0]           hi_sel;
  logic [COL_W-1:0]           clo, chi;
  logic signed [NUM_W-1:0]    v_sum;
  logic signed [NUM_W-1:0]    div_num;
  logic signed [DEN_W-1:0]    div_den;
  logic                       div_done;
  logic signed [NUM_W-1:0]    div_q;

  function automatic logic [COL_W-1:0] sat_chan(input logic signed [NUM_W-1:0] q);
    logic [COL_W-1:0] c;
    if (q < 0) begin
      c = '0;
    end else if (q > CHAN_TOP) begin
      c = '1;
    end else begin
      c = q[COL_W-1:0];
    end
    return c;
  endfunction

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_entries_r <= NE_W'(256);
    end else if (cfg_we) begin
      num_entries_r <= cfg_num_entries;
    end
  end

  // Point store write and point count.
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_point_index) < MAX_POINTS)) begin
      val_mem[PT_AW'(in_point_index)] <= in_point_value;
      col_mem[PT_AW'(in_point_index)] <=
        PCW'({in_point_alpha, in_point_blue, in_point_green, in_point_red});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load && (32'(in_point_index) < MAX_POINTS)) begin
      count_r <= CNT_W'(in_point_index) + CNT_W'(1);
    end
  end

  // Point store read address and registered read.
  always_comb begin
    last_addr = PT_AW'(count_r - CNT_W'(1));
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last_addr;
      RD_J:    rd_addr = j_r;
      RD_LO:   rd_addr = lo_i_r;
      RD_HI:   rd_addr = hi_i_r;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      vrd_r <= val_mem[rd_addr];
      crd_r <= col_mem[rd_addr];
    end
  end

  // Entry count clamp and entry index saturation.
  always_comb begin
    n_ext = NCL_W'(num_entries_r);
    if (n_ext < NCL_W'(2)) begin
      n_cl = NCL_W'(2);
    end else if (n_ext > ENT_MAX) begin
      n_cl = ENT_MAX;
    end else begin
      n_cl = n_ext;
    end
    d_full  = n_cl - NCL_W'(1);
    d_nxt   = NE_W'(d_full);
    idx_nxt = ({1'b0, in_entry_index} > d_nxt) ? d_nxt[IDX_W-1:0] : in_entry_index;
  end

  // Bracketing pair from the search position.
  always_comb begin
    hi_sel = (j_r == '0) ? PT_AW'(1) : j_r;
    v_sum  = NUM_W'(first_r) + div_q;
    clo    = lo_c_r[COL_W*ch_r +: COL_W];
    chi    = hi_c_r[COL_W*ch_r +: COL_W];
  end

  // Divider operand selection: entry value first, then one channel at a time.
  always_comb begin
    if (cmd.div_chan) begin
      div_num = cnum_r;
      div_den = span_r;
    end else begin
      div_num = num_r;
      div_den = DEN_W'(d_r);
    end
  end

  plcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .floor_md (!cmd.div_chan),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_q)
  );

  // Query working registers.
  always_ff @(posedge clk) begin
    if (cmd.start_q) begin
      idx_r   <= idx_nxt;
      d_r     <= d_nxt;
      lt2_q_r <= (count_r < CNT_W'(2));
    end
    if (cmd.latch_first) begin
      first_r <= vrd_r;
    end
    if (cmd.calc_diff) begin
      diff_r <= DEN_W'(vrd_r) - DEN_W'(first_r);
    end
    if (cmd.calc_mul) begin
      num_r <= NUM_W'(diff_r) * NUM_W'($signed({1'b0, idx_r}));
    end
    if (cmd.latch_v) begin
      v_r <= v_sum[VAL_W-1:0];
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + PT_AW'(1);
    end
    if (cmd.latch_pair) begin
      hi_i_r <= hi_sel;
      lo_i_r <= hi_sel - PT_AW'(1);
    end
    if (cmd.latch_lo) begin
      lo_v_r <= vrd_r;
      lo_c_r <= crd_r;
    end
    if (cmd.calc_span) begin
      hi_c_r <= crd_r;
      dhv_r  <= DEN_W'(vrd_r) - DEN_W'(v_r);
      dvl_r  <= DEN_W'(v_r) - DEN_W'(lo_v_r);
      span_r <= DEN_W'(vrd_r) - DEN_W'(lo_v_r);
      ch_r   <= '0;
    end else if (cmd.ch_inc) begin
      ch_r <= ch_r + CH_W'(1);
    end
    if (cmd.ch_mul) begin
      p1_r <= PROD_W'($signed({1'b0, clo})) * PROD_W'(dhv_r);
      p2_r <= PROD_W'($signed({1'b0, chi})) * PROD_W'(dvl_r);
    end
    if (cmd.ch_sum) begin
      cnum_r <= NUM_W'(p1_r) + NUM_W'(p2_r);
    end
    if (cmd.ch_store) begin
      res_r[ch_r] <= (span_r == '0) ? clo : sat_chan(div_q);
    end
  end

  // Result register: holds one finished transaction while the next query runs.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_r <= idx_r;
      out_mv_r    <= !lt2_q_r;
      for (int k = 0; k < CHANNELS; k++) begin
        out_col_r[k] <= lt2_q_r ? '0 : res_r[k];
      end
    end
  end

  // Channels beyond the configured number read zero.
  for (genvar k = 0; k < CH_MAX; k++) begin : g_col
    if (k < CHANNELS) begin : g_used
      assign col_o[k] = out_col_r[k];
    end else begin : g_unused
      assign col_o[k] = '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_entry_out = out_entry_r;
  assign out_map_valid = out_mv_r;
  assign out_red       = col_o[0];
  assign out_green     = col_o[1];
  assign out_blue      = col_o[2];
  assign out_alpha     = col_o[3];

  // Status back to the controller.
  always_comb begin
    sts.lt2        = (count_r < CNT_W'(2));
    sts.search_hit = (vrd_r >= v_r);
    sts.j_last     = ((CNT_W'(j_r) + CNT_W'(1)) == count_r);
    sts.div_done   = div_done;
    sts.span_zero  = (span_r == '0);
    sts.ch_last    = (32'(ch_r) == CHANNELS - 1);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // The divider is never started with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (div_den != '0))
    else $error("division started with zero divisor");

  // The bracketing pair is adjacent and lies inside the loaded points.
  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_pair |=> ((CNT_W'(hi_i_r) < count_r) && ((lo_i_r + PT_AW'(1)) == hi_i_r)))
    else $error("bracketing pair out of range");

endmodule

// ----- rtl/plcm_ctrl.sv -----
// Controller of the colour map: sequences loads and queries over the datapath.
// Talks to plcm_dpath through cmd_t/sts_t. Depends on plcm_pkg.
module plcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  plcm_pkg::sts_t  sts,
  output plcm_pkg::cmd_t  cmd
);
  import plcm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDF  = 5'd1;
  localparam logic [4:0] S_RDL  = 5'd2;
  localparam logic [4:0] S_DIFF = 5'd3;
  localparam logic [4:0] S_MUL  = 5'd4;
  localparam logic [4:0] S_DIV1 = 5'd5;
  localparam logic [4:0] S_DW1  = 5'd6;
  localparam logic [4:0] S_SADR = 5'd7;
  localparam logic [4:0] S_SCMP = 5'd8;
  localparam logic [4:0] S_RLO  = 5'd9;
  localparam logic [4:0] S_RHI  = 5'd10;
  localparam logic [4:0] S_SPAN = 5'd11;
  localparam logic [4:0] S_CMUL = 5'd12;
  localparam logic [4:0] S_CSUM = 5'd13;
  localparam logic [4:0] S_CDIV = 5'd14;
  localparam logic [4:0] S_DW2  = 5'd15;
  localparam logic [4:0] S_CSTO = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start_q = 1'b1;
            state_nxt   = sts.lt2 ? S_DONE : S_RDF;
          end
        end
      end
      S_RDF: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt  = S_RDL;
      end
      S_RDL: begin
        cmd.latch_first = 1'b1;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RD_LAST;
        state_nxt       = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DW1;
      end
      S_DW1: begin
        if (sts.div_done) begin
          cmd.latch_v = 1'b1;
          state_nxt   = S_SADR;
        end
      end
      S_SADR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_J;
        state_nxt  = S_SCMP;
      end
      S_SCMP: begin
        if (sts.search_hit || sts.j_last) begin
          cmd.latch_pair = 1'b1;
          state_nxt      = S_RLO;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SADR;
        end
      end
      S_RLO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_nxt  = S_RHI;
      end
      S_RHI: begin
        cmd.latch_lo = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_HI;
        state_nxt    = S_SPAN;
      end
      S_SPAN: begin
        cmd.calc_span = 1'b1;
        state_nxt     = S_CMUL;
      end
      S_CMUL: begin
        cmd.ch_mul = 1'b1;
        state_nxt  = S_CSUM;
      end
      S_CSUM: begin
        cmd.ch_sum = 1'b1;
        state_nxt  = sts.span_zero ? S_CSTO : S_CDIV;
      end
      S_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_chan  = 1'b1;
        state_nxt     = S_DW2;
      end
      S_DW2: begin
        cmd.div_chan = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_CSTO;
        end
      end
      S_CSTO: begin
        cmd.ch_store = 1'b1;
        if (sts.ch_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ch_inc = 1'b1;
          state_nxt  = S_CMUL;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A divider result only ever arrives while the controller waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> ((state_r == S_DW1) || (state_r == S_DW2)))
    else $error("divider result arrived outside a wait state");

endmodule

// ----- rtl/piecewise_linear_color_map.sv -----
// Top level of the piecewise-linear colour map: controller plus datapath.
// Depends on plcm_pkg, plcm_ctrl, plcm_dpath (and plcm_div below it).
//
//   Channel  Direction  Handshake              Payload
//   cfg_     in         cfg_valid/cfg_ready    cfg_num_entries
//   in_      in         in_valid/in_ready      kind, point slot/value/colour, entry index
//   out_     out        out_valid/out_ready    entry, RGBA colour, map valid
//
// A load is written at acceptance. A query holds off the next item until it has finished;
// its length grows with the number of points examined by the search and with CHANNELS. It
// is set by the shared bit-serial divider, which delivers one of 44 quotient bits per cycle,
// used once for the entry value and once per channel unless the bracketing points share a
// value. A query with fewer than two points skips the divider.
// Reset clears the controller, the point count and the output valid, and sets the
// entry count to 256; point storage holds no defined value until written.
// A result waiting on out_ready does not stop the next item from being accepted; only
// the hand-over of the following result waits for the output register to empty.
module piecewise_linear_color_map #(
  parameter int MAX_POINTS = 16,
  parameter int CHANNELS   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plcm_pkg::NE_W-1:0]            cfg_num_entries,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [plcm_pkg::PI_W-1:0]            in_point_index,
  input  logic signed [plcm_pkg::VAL_W-1:0]    in_point_value,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_red,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_green,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_blue,
  input  logic [plcm_pkg::COL_W-1:0]           in_point_alpha,
  input  logic [plcm_pkg::IDX_W-1:0]           in_entry_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [plcm_pkg::IDX_W-1:0]           out_entry_out,
  output logic [plcm_pkg::COL_W-1:0]           out_red,
  output logic [plcm_pkg::COL_W-1:0]           out_green,
  output logic [plcm_pkg::COL_W-1:0]           out_blue,
  output logic [plcm_pkg::COL_W-1:0]           out_alpha,
  output logic                                 out_map_valid
);
  import plcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The entry count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  plcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plcm_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .CHANNELS   (CHANNELS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid),
    .cfg_num_entries (cfg_num_entries),
    .in_point_index  (in_point_index),
    .in_point_value  (in_point_value),
    .in_point_red    (in_point_red),
    .in_point_green  (in_point_green),
    .in_point_blue   (in_point_blue),
    .in_point_alpha  (in_point_alpha),
    .in_entry_index  (in_entry_index),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_entry_out   (out_entry_out),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_map_valid   (out_map_valid),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
